@@ design/assert_macros.svh @@
// Assertion macros shared by the controller RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/cpmd_pkg.sv @@
// Package for the cascaded PID duty core: constants, codes and shared types.
// No dependencies.
package cpmd_pkg;

  localparam int GAIN_FRAC = 32;
  localparam int SH_TERM   = GAIN_FRAC - 15;
  localparam int SH_INTEG  = GAIN_FRAC + 20 - 15;

  localparam int MA_W = 48;
  localparam int MB_W = 32;
  localparam int MP_W = MA_W + MB_W;
  localparam int DN_W = 57;
  localparam int DD_W = 20;
  localparam int DC_W = $clog2(DN_W + 1);

  localparam logic signed [47:0] INTEG_LIMIT  = 48'sd10000000000000;
  localparam logic [19:0]        USEC_PER_SEC = 20'd1000000;
  localparam logic [47:0]        TERM_SAT     = 48'h8000_0000_0000;
  localparam logic signed [51:0] SUM_SAT      = 52'sh00100_0000_0000;

  typedef enum logic [2:0] {
    CFG_POS_P    = 3'd0,
    CFG_POS_I    = 3'd1,
    CFG_VEL_P    = 3'd2,
    CFG_VEL_D    = 3'd3,
    CFG_ACCEL_FF = 3'd4,
    CFG_FLOOR    = 3'd5,
    CFG_CEILING  = 3'd6,
    CFG_NOMINAL  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INT_MUL,
    S_INT_WAIT,
    S_DV_MUL,
    S_DV_WAIT,
    S_DV_DIV,
    S_TERM_MUL,
    S_TERM_WAIT,
    S_TERM_ACC,
    S_SAT,
    S_SC_MUL,
    S_SC_WAIT,
    S_SC_DIV,
    S_CLAMP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [DN_W-1:0] num;
    logic [DD_W-1:0] den;
  } div_req_t;

endpackage

@@ design/cascaded_pid_motor_duty_core.sv @@
// Cascaded position/velocity PID duty core: sequencer, state and datapath.
// Depends on cpmd_pkg, cpmd_mul, cpmd_div and assert_macros.svh.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | restart_i .. bus_mv_i
//  out     | output    | out_valid_o/out_ready_i | duty_o
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// A sample with bus compensation runs eight multiplies, two divides
// (velocity derivative and compensation) and the sequencer steps.
// Without compensation one multiply and one divide fewer; a zero time step
// goes straight to emit. While the output register stays full, the sequencer waits in emit.
// in_ready_o is high only in the idle state; one finished result may wait
// in the output register while the next sample is worked on.
// Reset restores the register defaults and clears integrator and history.
`include "assert_macros.svh"

module cascaded_pid_motor_duty_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  input  logic signed [31:0] pos_target_i,
  input  logic signed [23:0] vel_target_i,
  input  logic signed [31:0] accel_target_i,
  input  logic signed [31:0] pos_measured_i,
  input  logic signed [23:0] vel_measured_i,
  input  logic [19:0]        step_us_i,
  input  logic [15:0]        bus_mv_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] duty_o
);

  localparam logic [80:0] HALF_TERM  = 81'd1 << (cpmd_pkg::SH_TERM - 1);
  localparam logic [80:0] HALF_INTEG = 81'd1 << (cpmd_pkg::SH_INTEG - 1);

  cpmd_pkg::state_e state_q, state_d;

  // configuration
  logic signed [31:0] gpp_q, gpi_q, gvp_q, gvd_q, gff_q;
  logic signed [15:0] floor_q, ceil_q;
  logic [15:0]        nominal_q;

  // sample and state
  logic signed [31:0] pt_q, at_q, pm_q;
  logic signed [23:0] vt_q, vm_q;
  logic [19:0]        step_q;
  logic [15:0]        bus_q;
  logic signed [47:0] integ_q;
  logic signed [23:0] last_vel_q;
  logic               first_q;
  logic [47:0]        dvel_mag_q;
  logic               dvel_neg_q;
  logic [2:0]         idx_q;
  logic [47:0]        term_q;
  logic               term_neg_q;
  logic signed [51:0] sum_q;
  logic signed [57:0] scaled_q;
  logic signed [15:0] res_q, duty_q;
  logic               out_valid_q;

  // shared units
  cpmd_pkg::mul_req_t             mul_req;
  cpmd_pkg::div_req_t             div_req;
  logic                           mul_done, div_done;
  logic [cpmd_pkg::MP_W-1:0]      mp;
  logic [cpmd_pkg::DN_W-1:0]      dq;

  cpmd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mp)
  );

  cpmd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (dq)
  );

  // errors and magnitudes
  logic signed [32:0] pos_err, acc_ext;
  logic signed [24:0] vel_err, dv;
  logic [32:0]        pe_mag, acc_mag;
  logic [24:0]        ve_mag, dv_mag;
  logic [47:0]        integ_mag;
  logic [51:0]        sum_mag;

  assign pos_err   = {pt_q[31], pt_q} - {pm_q[31], pm_q};
  assign vel_err   = {vt_q[23], vt_q} - {vm_q[23], vm_q};
  assign dv        = {vm_q[23], vm_q} - {last_vel_q[23], last_vel_q};
  assign acc_ext   = {at_q[31], at_q};
  assign pe_mag    = pos_err[32] ? (33'd0 - pos_err) : pos_err;
  assign acc_mag   = acc_ext[32] ? (33'd0 - acc_ext) : acc_ext;
  assign ve_mag    = vel_err[24] ? (25'd0 - vel_err) : vel_err;
  assign dv_mag    = dv[24] ? (25'd0 - dv) : dv;
  assign integ_mag = integ_q[47] ? (48'd0 - integ_q) : integ_q;
  assign sum_mag   = sum_q[51] ? (52'd0 - sum_q) : sum_q;

  // integrator update with symmetric clamp
  logic [55:0]        ip_u;
  logic signed [55:0] ip_s, integ_sum, lim56;
  logic signed [47:0] integ_new;

  assign ip_u      = {1'b0, mp[54:0]};
  assign ip_s      = pos_err[32] ? (56'd0 - ip_u) : ip_u;
  assign integ_sum = {{8{integ_q[47]}}, integ_q} + ip_s;
  assign lim56     = {{8{cpmd_pkg::INTEG_LIMIT[47]}}, cpmd_pkg::INTEG_LIMIT};

  always_comb begin
    if (integ_sum > lim56) begin
      integ_new = cpmd_pkg::INTEG_LIMIT;
    end else if (integ_sum < -lim56) begin
      integ_new = -cpmd_pkg::INTEG_LIMIT;
    end else begin
      integ_new = integ_sum[47:0];
    end
  end

  // term operand selection
  logic signed [31:0] g_sel;
  logic [47:0]        v_sel;
  logic               vneg_sel;
  logic [31:0]        g_mag;

  always_comb begin
    unique case (idx_q)
      3'd0: begin
        g_sel = gpp_q; v_sel = {15'd0, pe_mag}; vneg_sel = pos_err[32];
      end
      3'd1: begin
        g_sel = gpi_q; v_sel = integ_mag; vneg_sel = integ_q[47];
      end
      3'd2: begin
        g_sel = gvp_q; v_sel = {23'd0, ve_mag}; vneg_sel = vel_err[24];
      end
      3'd3: begin
        g_sel = gvd_q; v_sel = dvel_mag_q; vneg_sel = dvel_neg_q;
      end
      default: begin
        g_sel = gff_q; v_sel = {15'd0, acc_mag}; vneg_sel = acc_ext[32];
      end
    endcase
  end

  assign g_mag = g_sel[31] ? (32'd0 - g_sel) : g_sel;

  // round half away from zero, saturate the magnitude
  logic [80:0] rnd, shr;
  logic [47:0] term_rnd;

  always_comb begin
    if (idx_q == 3'd1) begin
      rnd = {1'b0, mp} + HALF_INTEG;
      shr = rnd >> cpmd_pkg::SH_INTEG;
    end else begin
      rnd = {1'b0, mp} + HALF_TERM;
      shr = rnd >> cpmd_pkg::SH_TERM;
    end
    if ((|shr[80:48]) || (shr[47:0] > cpmd_pkg::TERM_SAT)) begin
      term_rnd = cpmd_pkg::TERM_SAT;
    end else begin
      term_rnd = shr[47:0];
    end
  end

  logic signed [51:0] term_s, sum_sat;
  assign term_s = term_neg_q ? (52'd0 - {4'd0, term_q}) : {4'd0, term_q};

  always_comb begin
    if (sum_q > cpmd_pkg::SUM_SAT) begin
      sum_sat = cpmd_pkg::SUM_SAT;
    end else if (sum_q < -cpmd_pkg::SUM_SAT) begin
      sum_sat = -cpmd_pkg::SUM_SAT;
    end else begin
      sum_sat = sum_q;
    end
  end

  // output clamp: ceiling first, floor last
  logic signed [57:0] ceil58, floor58, clamped;
  assign ceil58  = {{42{ceil_q[15]}}, ceil_q};
  assign floor58 = {{42{floor_q[15]}}, floor_q};

  always_comb begin
    clamped = scaled_q;
    if (clamped > ceil58) begin
      clamped = ceil58;
    end
    if (clamped < floor58) begin
      clamped = floor58;
    end
  end

  logic in_fire, out_free, comp_on;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign comp_on  = (nominal_q != 16'd0) && (bus_q != 16'd0);

  // sequencer: next state and unit requests
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    mul_req       = '0;
    div_req       = '0;
    unique case (state_q)
      cpmd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (step_us_i == 20'd0) ? cpmd_pkg::S_EMIT : cpmd_pkg::S_INT_MUL;
        end
      end
      cpmd_pkg::S_INT_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = {15'd0, pe_mag};
        mul_req.b     = {12'd0, step_q};
        state_d       = cpmd_pkg::S_INT_WAIT;
      end
      cpmd_pkg::S_INT_WAIT: begin
        if (mul_done) begin
          state_d = cpmd_pkg::S_DV_MUL;
        end
      end
      cpmd_pkg::S_DV_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = {23'd0, dv_mag};
        mul_req.b     = {12'd0, cpmd_pkg::USEC_PER_SEC};
        state_d       = cpmd_pkg::S_DV_WAIT;
      end
      cpmd_pkg::S_DV_WAIT: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.num   = mp[cpmd_pkg::DN_W-1:0];
          div_req.den   = step_q;
          state_d       = cpmd_pkg::S_DV_DIV;
        end
      end
      cpmd_pkg::S_DV_DIV: begin
        if (div_done) begin
          state_d = cpmd_pkg::S_TERM_MUL;
        end
      end
      cpmd_pkg::S_TERM_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = v_sel;
        mul_req.b     = g_mag;
        state_d       = cpmd_pkg::S_TERM_WAIT;
      end
      cpmd_pkg::S_TERM_WAIT: begin
        if (mul_done) begin
          state_d = cpmd_pkg::S_TERM_ACC;
        end
      end
      cpmd_pkg::S_TERM_ACC: begin
        state_d = (idx_q == 3'd4) ? cpmd_pkg::S_SAT : cpmd_pkg::S_TERM_MUL;
      end
      cpmd_pkg::S_SAT: begin
        state_d = comp_on ? cpmd_pkg::S_SC_MUL : cpmd_pkg::S_CLAMP;
      end
      cpmd_pkg::S_SC_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = sum_mag[47:0];
        mul_req.b     = {16'd0, nominal_q};
        state_d       = cpmd_pkg::S_SC_WAIT;
      end
      cpmd_pkg::S_SC_WAIT: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.num   = mp[cpmd_pkg::DN_W-1:0];
          div_req.den   = {4'd0, bus_q};
          state_d       = cpmd_pkg::S_SC_DIV;
        end
      end
      cpmd_pkg::S_SC_DIV: begin
        if (div_done) begin
          state_d = cpmd_pkg::S_CLAMP;
        end
      end
      cpmd_pkg::S_CLAMP: begin
        state_d = cpmd_pkg::S_EMIT;
      end
      cpmd_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = cpmd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cpmd_pkg::S_IDLE;
      end
    endcase
  end

  // state register and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpmd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_vel_q  <= '0;
      first_q     <= 1'b1;
      gpp_q       <= 32'sd214748;
      gpi_q       <= '0;
      gvp_q       <= 32'sd12885;
      gvd_q       <= '0;
      gff_q       <= '0;
      floor_q     <= 16'sh8000;
      ceil_q      <= 16'sh7FFF;
      nominal_q   <= '0;
    end else begin
      state_q <= state_d;
      // hand over the finished item to the output register
      if (state_q == cpmd_pkg::S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // restart clears history before the sample
      if (in_fire && restart_i) begin
        integ_q    <= '0;
        last_vel_q <= '0;
        first_q    <= 1'b1;
      end
      if (state_q == cpmd_pkg::S_INT_WAIT && mul_done) begin
        integ_q <= integ_new;
      end
      if (state_q == cpmd_pkg::S_DV_DIV && div_done) begin
        last_vel_q <= vm_q;
        first_q    <= 1'b0;
      end
      // register writes
      if (cfg_we_i) begin
        unique case (cpmd_pkg::cfg_idx_e'(cfg_idx_i))
          cpmd_pkg::CFG_POS_P:    gpp_q     <= cfg_data_i;
          cpmd_pkg::CFG_POS_I:    gpi_q     <= cfg_data_i;
          cpmd_pkg::CFG_VEL_P:    gvp_q     <= cfg_data_i;
          cpmd_pkg::CFG_VEL_D:    gvd_q     <= cfg_data_i;
          cpmd_pkg::CFG_ACCEL_FF: gff_q     <= cfg_data_i;
          cpmd_pkg::CFG_FLOOR:    floor_q   <= cfg_data_i[15:0];
          cpmd_pkg::CFG_CEILING:  ceil_q    <= cfg_data_i[15:0];
          cpmd_pkg::CFG_NOMINAL:  nominal_q <= cfg_data_i[15:0];
          default:                nominal_q <= nominal_q;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pt_q   <= pos_target_i;
      vt_q   <= vel_target_i;
      at_q   <= accel_target_i;
      pm_q   <= pos_measured_i;
      vm_q   <= vel_measured_i;
      step_q <= step_us_i;
      bus_q  <= bus_mv_i;
      sum_q  <= '0;
      idx_q  <= '0;
      res_q  <= '0;
    end
    if (state_q == cpmd_pkg::S_DV_DIV && div_done) begin
      dvel_mag_q <= first_q ? 48'd0 : dq[47:0];
      dvel_neg_q <= !dv[24] && (dv != 25'sd0);
    end
    if (state_q == cpmd_pkg::S_TERM_MUL) begin
      term_neg_q <= g_sel[31] ^ vneg_sel;
    end
    if (state_q == cpmd_pkg::S_TERM_WAIT && mul_done) begin
      term_q <= term_rnd;
    end
    if (state_q == cpmd_pkg::S_TERM_ACC) begin
      sum_q <= sum_q + term_s;
      idx_q <= idx_q + 3'd1;
    end
    if (state_q == cpmd_pkg::S_SAT) begin
      sum_q    <= sum_sat;
      scaled_q <= {{6{sum_sat[51]}}, sum_sat};
    end
    if (state_q == cpmd_pkg::S_SC_DIV && div_done) begin
      scaled_q <= sum_q[51] ? (58'd0 - {1'b0, dq}) : {1'b0, dq};
    end
    if (state_q == cpmd_pkg::S_CLAMP) begin
      res_q <= clamped[15:0];
    end
    if (state_q == cpmd_pkg::S_EMIT && out_free) begin
      duty_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;

  // checks on the sequencer
  `ASSERT_CLK(a_units_exclusive, !(mul_done && div_done), "mul and div done together")
  `ASSERT_CLK(a_busy_after_accept, in_fire |=> !in_ready_o, "accepted a second item")
  `ASSERT_CLK(a_zero_step_emit, in_fire && (step_us_i == 20'd0) |=> state_q == cpmd_pkg::S_EMIT,
    "zero step did not go straight to emit")

endmodule

@@ design/cpmd_mul.sv @@
// Shared unsigned multiplier: 48 x 32 bits over two passes of a 48 x 16 array.
// Depends on cpmd_pkg.
module cpmd_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cpmd_pkg::mul_req_t        req_i,
  output logic                      done_o,
  output logic [cpmd_pkg::MP_W-1:0] prod_o
);

  logic [cpmd_pkg::MA_W-1:0] a_q;
  logic [cpmd_pkg::MB_W-1:0] b_q;
  logic [cpmd_pkg::MP_W-1:0] acc_q;
  logic                      busy_q, phase_q, done_q;
  logic [15:0]               b_half;
  logic [63:0]               part;

  // pick the low half first, then the high half
  assign b_half = phase_q ? b_q[31:16] : b_q[15:0];
  assign part   = a_q * b_half;

  // control: two passes, then a one-cycle done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
      end else if (busy_q) begin
        phase_q <= 1'b1;
        if (phase_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      if (phase_q) begin
        acc_q <= acc_q + {part, 16'd0};
      end else begin
        acc_q <= {16'd0, part};
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ design/cpmd_div.sv @@
// Restoring divider, one quotient bit a cycle, 57-bit dividend by 20-bit divisor.
// Depends on cpmd_pkg.
module cpmd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cpmd_pkg::div_req_t        req_i,
  output logic                      done_o,
  output logic [cpmd_pkg::DN_W-1:0] quot_o
);

  logic [cpmd_pkg::DN_W-1:0] quo_q;
  logic [cpmd_pkg::DD_W-1:0] den_q;
  logic [cpmd_pkg::DD_W-1:0] rem_q;
  logic [cpmd_pkg::DC_W-1:0] cnt_q;
  logic                      busy_q, done_q;
  logic [cpmd_pkg::DD_W:0]   shifted;
  logic [cpmd_pkg::DD_W:0]   trial;

  // shift in the next dividend bit and try the subtraction
  assign shifted = {rem_q, quo_q[cpmd_pkg::DN_W-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cpmd_pkg::DC_W'(cpmd_pkg::DN_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == cpmd_pkg::DC_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend and quotient share the shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      if (trial[cpmd_pkg::DD_W]) begin
        rem_q <= shifted[cpmd_pkg::DD_W-1:0];
        quo_q <= {quo_q[cpmd_pkg::DN_W-2:0], 1'b0};
      end else begin
        rem_q <= trial[cpmd_pkg::DD_W-1:0];
        quo_q <= {quo_q[cpmd_pkg::DN_W-2:0], 1'b1};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
